FILE: hdl/dmrpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrpd_pkg
// Shared types, codes and constants for the dual motor ramped PWM duty block.
// ----------------------------------------------------------------------------
package dmrpd_pkg;

	localparam int unsigned SPEED_W  = 10;
	localparam int unsigned STEP_W   = 9;
	localparam int unsigned PULSE_W  = 11;
	localparam int unsigned DUTY_W   = 12;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 11;

	localparam int unsigned DUTY_PER_PERCENT_DEF = 24;

	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic [STEP_W-1:0]         step_t;
	typedef logic [PULSE_W-1:0]        pulse_t;
	typedef logic [DUTY_W-1:0]         duty_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

	// item kinds
	localparam logic KIND_SET  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// motor select
	localparam logic MOTOR_LEFT  = 1'b0;
	localparam logic MOTOR_RIGHT = 1'b1;

	// register indexes
	localparam cfg_idx_t CFG_RAMP_STEP     = 1'd0;
	localparam cfg_idx_t CFG_MINIMUM_PULSE = 1'd1;

	localparam step_t  RAMP_STEP_RST     = 9'd1;
	localparam pulse_t MINIMUM_PULSE_RST = 11'd50;
	localparam duty_t  DUTY_MAX          = 12'd4095;

	localparam speed_t SPEED_MAX = 10'sd511;
	localparam speed_t SPEED_MIN = -10'sd512;

	typedef struct packed {
		step_t  ramp_step;
		pulse_t minimum_pulse;
	} cfg_regs_t;

	typedef struct packed {
		logic   set_en;
		logic   tick_en;
		speed_t target;
	} motor_ctl_t;

endpackage

FILE: hdl/dmrpd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrpd_if
// Valid/ready channels: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface dmrpd_in_if;
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic                 motor;
	dmrpd_pkg::speed_t    target_speed;

	modport source (output valid, output kind, output motor, output target_speed,
		input ready);
	modport sink (input valid, input kind, input motor, input target_speed,
		output ready);
endinterface

interface dmrpd_out_if;
	logic                 valid;
	logic                 ready;
	dmrpd_pkg::duty_t     left_primary_duty;
	dmrpd_pkg::duty_t     left_secondary_duty;
	dmrpd_pkg::duty_t     right_primary_duty;
	dmrpd_pkg::duty_t     right_secondary_duty;

	modport source (output valid, output left_primary_duty, output left_secondary_duty,
		output right_primary_duty, output right_secondary_duty, input ready);
	modport sink (input valid, input left_primary_duty, input left_secondary_duty,
		input right_primary_duty, input right_secondary_duty, output ready);
endinterface

interface dmrpd_cfg_if;
	logic                 valid;
	logic                 ready;
	dmrpd_pkg::cfg_idx_t  index;
	dmrpd_pkg::cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/dmrpd_motor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrpd_motor
// One motor: target and current speed, slew-limited ramp, duty mapping.
// ----------------------------------------------------------------------------
module dmrpd_motor #(
	parameter int unsigned DUTY_PER_PERCENT = dmrpd_pkg::DUTY_PER_PERCENT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dmrpd_pkg::cfg_regs_t  cfg_regs,
	input  dmrpd_pkg::motor_ctl_t ctl,
	output dmrpd_pkg::duty_t      primary_duty,
	output dmrpd_pkg::duty_t      secondary_duty
);
	import dmrpd_pkg::*;

	localparam int unsigned RAMP_W = SPEED_W + 1;
	localparam int unsigned PROD_W = SPEED_W + $clog2(DUTY_PER_PERCENT + 1);
	localparam int unsigned SCL_W  = PROD_W - 2;
	localparam int unsigned SUM_W  = ((SCL_W > PULSE_W) ? SCL_W : PULSE_W) + 1;

	speed_t target_q;
	speed_t current_q;
	speed_t current_nxt;

	logic signed [RAMP_W-1:0] cur_x, tgt_x, step_x, up, dn;
	logic [SPEED_W-1:0]       mag;
	logic [PROD_W-1:0]        prod;
	logic [SUM_W-1:0]         drive_sum;
	duty_t                    drive;
	duty_t                    base;
	logic                     positive;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			current_q <= '0;
		end else begin
			if (ctl.set_en) begin
				target_q <= ctl.target;
			end
			if (ctl.tick_en) begin
				current_q <= current_nxt;
			end
		end
	end

	// step toward target, clamp at target so it never overshoots
	always_comb begin
		cur_x  = RAMP_W'(current_q);
		tgt_x  = RAMP_W'(target_q);
		step_x = $signed({2'b00, cfg_regs.ramp_step});
		up     = cur_x + step_x;
		dn     = cur_x - step_x;
		if (cur_x < tgt_x) begin
			current_nxt = (up < tgt_x) ? speed_t'(up) : target_q;
		end else if (cur_x > tgt_x) begin
			current_nxt = (dn > tgt_x) ? speed_t'(dn) : target_q;
		end else begin
			current_nxt = current_q;
		end
	end

	// duty = |speed| * DUTY_PER_PERCENT / 4 + minimum pulse, saturated
	always_comb begin
		mag       = current_nxt[SPEED_W-1] ? (~current_nxt + 1'b1) : current_nxt;
		prod      = PROD_W'(mag) * PROD_W'(DUTY_PER_PERCENT);
		drive_sum = SUM_W'(prod[PROD_W-1:2]) + SUM_W'(cfg_regs.minimum_pulse);
		drive     = (drive_sum > SUM_W'(DUTY_MAX)) ? DUTY_MAX : drive_sum[DUTY_W-1:0];
		base      = DUTY_W'(cfg_regs.minimum_pulse);
		positive  = !current_nxt[SPEED_W-1] && (current_nxt != '0);
		primary_duty   = positive ? drive : base;
		secondary_duty = positive ? base : drive;
	end

endmodule

FILE: hdl/dual_motor_ramped_pwm_duty.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_ramped_pwm_duty
// Two-motor speed slew limiter driving four H-bridge PWM duty counts.
// ----------------------------------------------------------------------------
// Takes one item per clock. A set beat stores a target speed (the right
// motor's target is stored negated, -512 becomes 511) and gives no result.
// A tick beat ramps both motors toward their targets by at most ramp_step
// and returns one result beat carrying four 12-bit duties: the item passes
// through the input register, and the ramp and duty logic then feed the
// result register. Throughput is one item per cycle; it drops only while
// the result register waits on the sink, since a second tick then holds in
// the input register. Registers are written through the cfg channel, which
// is always ready.
module dual_motor_ramped_pwm_duty #(
	parameter int unsigned DUTY_PER_PERCENT = dmrpd_pkg::DUTY_PER_PERCENT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	dmrpd_in_if.sink     item_in,
	dmrpd_out_if.source  result_out,
	dmrpd_cfg_if.sink    cfg
);
	import dmrpd_pkg::*;

	cfg_regs_t  cfg_regs;
	logic       valid_s1;
	logic       kind_s1;
	logic       motor_s1;
	speed_t     target_s1;
	logic       adv_s1;
	logic       out_valid_q;
	duty_t      lp_q, ls_q, rp_q, rs_q;
	duty_t      lp, ls, rp, rs;
	speed_t     neg_target;
	motor_ctl_t left_ctl, right_ctl;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs.ramp_step     <= RAMP_STEP_RST;
			cfg_regs.minimum_pulse <= MINIMUM_PULSE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_RAMP_STEP: begin
					cfg_regs.ramp_step <= cfg.data[STEP_W-1:0];
				end
				CFG_MINIMUM_PULSE: begin
					cfg_regs.minimum_pulse <= cfg.data[PULSE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// stage 1 moves on unless it holds a tick and the result register is stuck
	assign adv_s1 = valid_s1 &&
		((kind_s1 == KIND_SET) || !out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.ready && item_in.valid) begin
			kind_s1   <= item_in.kind;
			motor_s1  <= item_in.motor;
			target_s1 <= item_in.target_speed;
		end
	end

	assign neg_target = (target_s1 == SPEED_MIN) ? SPEED_MAX : -target_s1;

	always_comb begin
		left_ctl.set_en   = adv_s1 && (kind_s1 == KIND_SET) && (motor_s1 == MOTOR_LEFT);
		left_ctl.tick_en  = adv_s1 && (kind_s1 == KIND_TICK);
		left_ctl.target   = target_s1;
		right_ctl.set_en  = adv_s1 && (kind_s1 == KIND_SET) && (motor_s1 == MOTOR_RIGHT);
		right_ctl.tick_en = adv_s1 && (kind_s1 == KIND_TICK);
		right_ctl.target  = neg_target;
	end

	dmrpd_motor #(
		.DUTY_PER_PERCENT (DUTY_PER_PERCENT)
	) u_left (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_regs       (cfg_regs),
		.ctl            (left_ctl),
		.primary_duty   (lp),
		.secondary_duty (ls)
	);

	dmrpd_motor #(
		.DUTY_PER_PERCENT (DUTY_PER_PERCENT)
	) u_right (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_regs       (cfg_regs),
		.ctl            (right_ctl),
		.primary_duty   (rp),
		.secondary_duty (rs)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && (kind_s1 == KIND_TICK)) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && (kind_s1 == KIND_TICK)) begin
			lp_q <= lp;
			ls_q <= ls;
			rp_q <= rp;
			rs_q <= rs;
		end
	end

	assign result_out.valid                = out_valid_q;
	assign result_out.left_primary_duty    = lp_q;
	assign result_out.left_secondary_duty  = ls_q;
	assign result_out.right_primary_duty   = rp_q;
	assign result_out.right_secondary_duty = rs_q;

	// a result beat only ever comes from a tick leaving stage 1
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && (kind_s1 == KIND_TICK)))
		else $error("result beat without a tick");

	// input back-pressure only while stage 1 is occupied
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!item_in.ready |-> valid_s1)
		else $error("input stalled with empty stage 1");

	// stage 1 holds only a tick blocked by a stalled result
	a_hold_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |->
			((kind_s1 == KIND_TICK) && out_valid_q && !result_out.ready))
		else $error("stage 1 held without cause");

	// a tick stalled in stage 1 must not touch motor state
	a_no_tick_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> !left_ctl.tick_en && !right_ctl.tick_en)
		else $error("ramp advanced on a held tick");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dual motor ramped PWM duty block.
// A short table of directed items and register writes runs first. Random
// phases follow, each under its own ramp step and minimum pulse. Every tick
// is predicted from a local model of the targets, current speeds and duty
// mapping. Each result beat is compared field by field with the oldest
// prediction. The input side sends in bursts with gaps, and the result side
// stalls on its own pattern, once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
	import dmrpd_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 240;
	localparam int MAX_REPORTS  = 40;

	typedef struct packed {
		duty_t left_pri;
		duty_t left_sec;
		duty_t right_pri;
		duty_t right_sec;
	} duty_set_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_op_t;

	typedef struct packed {
		row_op_t   op;
		logic      kind;
		logic      motor;
		speed_t    tgt;
		cfg_idx_t  idx;
		cfg_data_t data;
		logic      typed;
		duty_set_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	dmrpd_in_if  item_ch ();
	dmrpd_out_if result_ch ();
	dmrpd_cfg_if reg_ch ();

	dual_motor_ramped_pwm_duty uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_ch),
		.result_out (result_ch),
		.cfg        (reg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// local copy of the block's state and registers
	step_t  ramp_step_q;
	pulse_t min_pulse_q;
	speed_t left_tgt, right_tgt, left_cur, right_cur;

	duty_set_t expected_duties[$];
	row_t      plan[$];
	int        mismatches = 0;
	int        cycles = 0;
	int        burst_left = 0;

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic speed_t ramp_toward(int cur, int tgt);
		int s;
		s = int'(ramp_step_q);
		if (cur < tgt)
			cur = (cur + s < tgt) ? cur + s : tgt;
		else if (cur > tgt)
			cur = (cur - s > tgt) ? cur - s : tgt;
		return speed_t'(cur);
	endfunction

	function automatic void bridge_duties(speed_t spd, output duty_t pri, output duty_t sec);
		int s, drive;
		s = int'(spd);
		drive = ((s < 0) ? -s : s) * int'(DUTY_PER_PERCENT_DEF) / 4 + int'(min_pulse_q);
		if (drive > int'(DUTY_MAX))
			drive = int'(DUTY_MAX);
		if (s > 0) begin
			pri = duty_t'(drive);
			sec = duty_t'(min_pulse_q);
		end else begin
			pri = duty_t'(min_pulse_q);
			sec = duty_t'(drive);
		end
	endfunction

	// returns 1 when the item yields a result beat
	function automatic bit advance_motors(logic kind, logic motor, speed_t tgt,
		output duty_set_t d);
		int n;
		d = '0;
		if (kind == KIND_SET) begin
			if (motor == MOTOR_RIGHT) begin
				n = -int'(tgt);
				right_tgt = speed_t'((n > 511) ? 511 : n);
			end else begin
				left_tgt = tgt;
			end
			return 1'b0;
		end
		left_cur  = ramp_toward(left_cur, left_tgt);
		right_cur = ramp_toward(right_cur, right_tgt);
		bridge_duties(left_cur, d.left_pri, d.left_sec);
		bridge_duties(right_cur, d.right_pri, d.right_sec);
		return 1'b1;
	endfunction

	function automatic void row_item(logic kind, logic motor, int tgt);
		row_t r;
		r = '0;
		r.op = ROW_ITEM;
		r.kind = kind;
		r.motor = motor;
		r.tgt = speed_t'(tgt);
		plan.push_back(r);
	endfunction

	function automatic void row_check(logic kind, logic motor, int tgt,
		int lp, int ls, int rp, int rs);
		row_t r;
		r = '0;
		r.op = ROW_ITEM;
		r.kind = kind;
		r.motor = motor;
		r.tgt = speed_t'(tgt);
		r.typed = 1'b1;
		r.want = '{duty_t'(lp), duty_t'(ls), duty_t'(rp), duty_t'(rs)};
		plan.push_back(r);
	endfunction

	function automatic void row_write(cfg_idx_t idx, int data);
		row_t r;
		r = '0;
		r.op = ROW_WRITE;
		r.idx = idx;
		r.data = cfg_data_t'(data);
		plan.push_back(r);
	endfunction

	task automatic offer_item(logic kind, logic motor, speed_t tgt, logic typed,
		duty_set_t want);
		int gap;
		duty_set_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		item_ch.valid        <= 1'b1;
		item_ch.kind         <= kind;
		item_ch.motor        <= motor;
		item_ch.target_speed <= tgt;
		do @(posedge clk); while (!item_ch.ready);
		if (advance_motors(kind, motor, tgt, predicted))
			expected_duties.push_back(typed ? want : predicted);
	endtask

	// writes only once the block has drained
	task automatic write_register(cfg_idx_t idx, cfg_data_t val);
		item_ch.valid <= 1'b0;
		while (expected_duties.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		reg_ch.valid <= 1'b1;
		reg_ch.index <= idx;
		reg_ch.data  <= val;
		do @(posedge clk); while (!reg_ch.ready);
		reg_ch.valid <= 1'b0;
		if (idx == CFG_RAMP_STEP)
			ramp_step_q = val[STEP_W-1:0];
		else if (idx == CFG_MINIMUM_PULSE)
			min_pulse_q = val[PULSE_W-1:0];
	endtask

	// result side: random stall modes, plus one long hold-off
	initial begin
		int mode, mode_left, hold_left, beats;
		bit hold_done;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		beats = 0;
		hold_done = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				beats++;
			if (!hold_done && beats == 300) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= 1'($urandom_range(0, 1));
					2: result_ch.ready <= ($urandom_range(0, 3) == 0);
					default: result_ch.ready <= ~result_ch.ready;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		duty_set_t got, want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{result_ch.left_primary_duty, result_ch.left_secondary_duty,
				result_ch.right_primary_duty, result_ch.right_secondary_duty};
			if (expected_duties.size() == 0) begin
				report_mismatch("result beat with nothing expected", 1, 0);
			end else begin
				want = expected_duties.pop_front();
				if (got.left_pri !== want.left_pri)
					report_mismatch("left_primary_duty", int'(got.left_pri),
						int'(want.left_pri));
				if (got.left_sec !== want.left_sec)
					report_mismatch("left_secondary_duty", int'(got.left_sec),
						int'(want.left_sec));
				if (got.right_pri !== want.right_pri)
					report_mismatch("right_primary_duty", int'(got.right_pri),
						int'(want.right_pri));
				if (got.right_sec !== want.right_sec)
					report_mismatch("right_secondary_duty", int'(got.right_sec),
						int'(want.right_sec));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int ph, i, drain, tgt;
		logic kind, motor;
		int step_val, pulse_val;
		duty_set_t none;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_SET;
		item_ch.motor = MOTOR_LEFT;
		item_ch.target_speed = '0;
		reg_ch.valid = 1'b0;
		reg_ch.index = CFG_RAMP_STEP;
		reg_ch.data = '0;
		none = '0;

		ramp_step_q = RAMP_STEP_RST;
		min_pulse_q = MINIMUM_PULSE_RST;
		left_tgt = '0;
		right_tgt = '0;
		left_cur = '0;
		right_cur = '0;

		// zero speed after reset; motor and target are don't-care on ticks
		row_check(KIND_TICK, MOTOR_LEFT, 0, 50, 50, 50, 50);
		row_check(KIND_TICK, MOTOR_RIGHT, -512, 50, 50, 50, 50);
		// step field truncates to 511; right -512 negates to 511
		row_write(CFG_RAMP_STEP, 2047);
		row_item(KIND_SET, MOTOR_LEFT, 511);
		row_item(KIND_SET, MOTOR_RIGHT, -512);
		row_check(KIND_TICK, MOTOR_LEFT, 0, 3116, 50, 3116, 50);
		// drive saturates
		row_write(CFG_MINIMUM_PULSE, 2047);
		row_check(KIND_TICK, MOTOR_LEFT, 0, 4095, 2047, 4095, 2047);
		row_write(CFG_MINIMUM_PULSE, 0);
		row_item(KIND_SET, MOTOR_LEFT, -512);
		row_item(KIND_SET, MOTOR_RIGHT, 511);
		row_check(KIND_TICK, MOTOR_LEFT, 0, 0, 0, 0, 0);
		row_item(KIND_TICK, MOTOR_RIGHT, 0);
		row_item(KIND_TICK, MOTOR_LEFT, 0);
		// frozen speeds
		row_write(CFG_RAMP_STEP, 0);
		row_item(KIND_SET, MOTOR_LEFT, 400);
		row_item(KIND_TICK, MOTOR_LEFT, 0);
		row_write(CFG_RAMP_STEP, 1);
		row_write(CFG_MINIMUM_PULSE, 1600);
		row_item(KIND_SET, MOTOR_RIGHT, -400);
		row_item(KIND_TICK, MOTOR_LEFT, 0);
		// targets beyond the nominal range, then near zero
		row_item(KIND_SET, MOTOR_LEFT, 450);
		row_item(KIND_SET, MOTOR_RIGHT, -450);
		row_item(KIND_SET, MOTOR_LEFT, -1);
		row_item(KIND_SET, MOTOR_RIGHT, 1);
		row_item(KIND_TICK, MOTOR_RIGHT, 1);
		row_item(KIND_SET, MOTOR_RIGHT, 0);
		row_item(KIND_TICK, MOTOR_LEFT, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[n]) begin
			if (plan[n].op == ROW_WRITE)
				write_register(plan[n].idx, plan[n].data);
			else
				offer_item(plan[n].kind, plan[n].motor, plan[n].tgt, plan[n].typed,
					plan[n].want);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin step_val = 1; pulse_val = 0; end
				1: begin step_val = 2047; pulse_val = 2047; end
				2: begin step_val = 0; pulse_val = 1600; end
				3: begin step_val = 400; pulse_val = 50; end
				default: begin
					step_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
						: $urandom_range(1, 400);
					pulse_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
						: $urandom_range(0, 1600);
				end
			endcase
			write_register(CFG_RAMP_STEP, cfg_data_t'(step_val));
			write_register(CFG_MINIMUM_PULSE, cfg_data_t'(pulse_val));
			for (i = 0; i < PHASE_ITEMS; i++) begin
				kind  = ($urandom_range(0, 99) < 45) ? KIND_TICK : KIND_SET;
				motor = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 9))
					0: begin
						case ($urandom_range(0, 6))
							0: tgt = -512;
							1: tgt = 511;
							2: tgt = -400;
							3: tgt = 400;
							4: tgt = 0;
							5: tgt = -1;
							default: tgt = 1;
						endcase
					end
					1, 2: tgt = $urandom_range(0, 1023) - 512;
					default: tgt = $urandom_range(0, 800) - 400;
				endcase
				offer_item(kind, motor, speed_t'(tgt), 1'b0, none);
			end
		end

		item_ch.valid <= 1'b0;
		drain = 0;
		while (expected_duties.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (expected_duties.size() != 0)
			report_mismatch("result beats never returned", 0, expected_duties.size());

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
